// File: sv/dma_channel_engine_core_macros.svh
// assertion macros for the dma channel engine checker
`ifndef DMA_CHANNEL_ENGINE_CORE_MACROS_SVH
`define DMA_CHANNEL_ENGINE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define DCE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dce_pkg.sv
// shared types and codes of the dma channel engine
package dce_pkg;

  // operation codes of an input beat
  localparam logic [1:0] OpM2d  = 2'd0;
  localparam logic [1:0] OpD2m  = 2'd1;
  localparam logic [1:0] OpTick = 2'd2;
  localparam logic [1:0] OpNone = 2'd3;

  // result kinds
  localparam logic KindAnswer = 1'b0;
  localparam logic KindXfer   = 1'b1;

  // input beat payload
  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  channel;
    logic [7:0]  target;
    logic [15:0] length;
    logic [15:0] device_addr;
    logic [15:0] mem_addr;
  } in_item_t;

  // result beat payload
  typedef struct packed {
    logic        kind;
    logic        accepted;
    logic [1:0]  chan_out;
    logic [7:0]  target_out;
    logic        to_memory;
    logic [15:0] mem_addr_out;
    logic [15:0] device_addr_out;
    logic        channel_done;
    logic        last;
  } out_item_t;

  // one row of the channel table
  typedef struct packed {
    logic [15:0] remaining;
    logic [15:0] mem_pointer;
    logic [15:0] device_pointer;
    logic        direction;
    logic [7:0]  target_id;
  } chan_entry_t;

endpackage

// File: sv/dce_if.sv
// valid/ready channels of the dma channel engine

// request and tick beats
interface dce_in_if;
  logic               valid;
  logic               ready;
  dce_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// answer and transfer command beats
interface dce_out_if;
  logic               valid;
  logic               ready;
  dce_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/dce_chan_mem.sv
// channel table memory, one write port and one registered read port
module dce_chan_mem #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW    = 2
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  dce_pkg::chan_entry_t wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output dce_pkg::chan_entry_t rdata_o
);

  dce_pkg::chan_entry_t mem_q [DEPTH];
  dce_pkg::chan_entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/dma_channel_engine_core.sv
// dma channel engine: a request goes from S_IDLE to S_REQ, a tick from S_IDLE to S_SCAN
// each active channel is S_SCAN, a read of the table, then S_RMW, its write back
// a tick with no active channel returns from S_SCAN to S_IDLE, op 3 is dropped on acceptance
// results leave through one output register; a stalled sink holds the sequencer
// reset clears the busy flags, the sequencer and the output valid; the table rows are
// not cleared, and a row is only read while its busy flag is set
module dma_channel_engine_core #(
  parameter int unsigned CHANNELS   = 4,
  parameter int unsigned WORD_BYTES = 2
) (
  input logic       clk_i,
  input logic       rst_ni,
  dce_in_if.sink    in_i,
  dce_out_if.source out_o
);

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SW = $clog2(CHANNELS + 1);
  localparam logic [15:0] MemStep = 16'(WORD_BYTES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_REQ  = 4'b0010,
    S_SCAN = 4'b0100,
    S_RMW  = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  dce_pkg::in_item_t    item_q, item_d;
  logic [CHANNELS-1:0]  busy_q, busy_d;
  logic [SW-1:0]        scan_q, scan_d;
  logic [CW-1:0]        cur_q, cur_d;
  logic                 out_valid_q, out_valid_d;
  dce_pkg::out_item_t   out_data_q, out_data_d;

  logic                 mem_we;
  logic [CW-1:0]        mem_waddr;
  dce_pkg::chan_entry_t mem_wdata;
  logic                 mem_re;
  dce_pkg::chan_entry_t mem_rdata;

  logic [4:0]           req_ch;
  logic [CW-1:0]        req_idx;
  logic                 req_ok;
  logic                 nxt_found;
  logic [CW-1:0]        nxt_idx;
  logic                 later_busy;
  logic [4:0]           cur_ext;
  logic                 out_free;
  logic                 xfer_done;

  // channel table
  dce_chan_mem #(
    .DEPTH (CHANNELS),
    .AW    (CW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (nxt_idx),
    .rdata_o (mem_rdata)
  );

  // request decode against the busy flags
  assign req_ch  = {3'b000, item_q.channel};
  assign req_idx = req_ch[CW-1:0];
  assign req_ok  = (req_ch < 5'(CHANNELS)) && !busy_q[req_idx];

  // lowest busy channel at or above the scan position
  always_comb begin
    nxt_found = 1'b0;
    nxt_idx   = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (busy_q[c] && (SW'(c) >= scan_q)) begin
        nxt_found = 1'b1;
        nxt_idx   = CW'(c);
      end
    end
  end

  // any busy channel after the current one
  always_comb begin
    later_busy = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (busy_q[c] && (CW'(c) > cur_q)) begin
        later_busy = 1'b1;
      end
    end
  end

  assign cur_ext   = 5'(cur_q);
  assign out_free  = !out_valid_q || out_o.ready;
  assign xfer_done = (mem_rdata.remaining == 16'd1);

  // sequencer
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    busy_d      = busy_q;
    scan_d      = scan_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = req_idx;
    mem_wdata   = '0;
    mem_re      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          item_d = in_i.data;
          if (in_i.data.op == dce_pkg::OpM2d || in_i.data.op == dce_pkg::OpD2m) begin
            state_d = S_REQ;
          end else if (in_i.data.op == dce_pkg::OpTick) begin
            scan_d  = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_REQ: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_data_d          = '0;
          out_data_d.kind     = dce_pkg::KindAnswer;
          out_data_d.accepted = req_ok;
          out_data_d.chan_out = item_q.channel;
          out_data_d.last     = 1'b1;
          if (req_ok) begin
            mem_we                   = 1'b1;
            mem_waddr                = req_idx;
            mem_wdata.remaining      = item_q.length;
            mem_wdata.mem_pointer    = item_q.mem_addr;
            mem_wdata.device_pointer = item_q.device_addr;
            mem_wdata.direction      = (item_q.op == dce_pkg::OpD2m);
            mem_wdata.target_id      = item_q.target;
            busy_d[req_idx]          = (item_q.length != 16'd0);
          end
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (nxt_found) begin
          mem_re  = 1'b1;
          cur_d   = nxt_idx;
          state_d = S_RMW;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RMW: begin
        if (out_free) begin
          out_valid_d                = 1'b1;
          out_data_d.kind            = dce_pkg::KindXfer;
          out_data_d.accepted        = 1'b0;
          out_data_d.chan_out        = cur_ext[1:0];
          out_data_d.target_out      = mem_rdata.target_id;
          out_data_d.to_memory       = mem_rdata.direction;
          out_data_d.mem_addr_out    = mem_rdata.mem_pointer;
          out_data_d.device_addr_out = mem_rdata.device_pointer;
          out_data_d.channel_done    = xfer_done;
          out_data_d.last            = !later_busy;
          // write back the advanced row
          mem_we                   = 1'b1;
          mem_waddr                = cur_q;
          mem_wdata                = mem_rdata;
          mem_wdata.remaining      = mem_rdata.remaining - 16'd1;
          mem_wdata.mem_pointer    = mem_rdata.mem_pointer + MemStep;
          mem_wdata.device_pointer = mem_rdata.device_pointer + 16'd1;
          busy_d[cur_q]            = !xfer_done;
          scan_d                   = SW'(cur_q) + SW'(1);
          state_d                  = S_SCAN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    scan_q     <= scan_d;
    cur_q      <= cur_d;
    out_data_q <= out_data_d;
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// File: sv/dce_checker.sv
// port-level checks of the dma channel engine and their bind
`include "dma_channel_engine_core_macros.svh"

module dce_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic [1:0]         in_op_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input dce_pkg::out_item_t out_data_i
);

  // a stalled result beat holds
  `DCE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_data_i), "result beat changed while stalled")

  // a request or tick beat blocks the input while it is worked on
  `DCE_ASSERT_NEXT(a_one_item, clk_i, rst_ni,
    in_valid_i && in_ready_i && (in_op_i != dce_pkg::OpNone), !in_ready_i,
    "input taken while a beat is in work")

  // an answer is a lone last beat with no transfer fields
  `DCE_ASSERT_IMPL(a_answer_form, clk_i, rst_ni,
    out_valid_i && (out_data_i.kind == dce_pkg::KindAnswer),
    out_data_i.last && !out_data_i.channel_done && (out_data_i.target_out == 8'd0) &&
    (out_data_i.mem_addr_out == 16'd0) && (out_data_i.device_addr_out == 16'd0) &&
    !out_data_i.to_memory, "malformed request answer")

  // a transfer command never carries an accept flag
  `DCE_ASSERT_IMPL(a_xfer_form, clk_i, rst_ni,
    out_valid_i && (out_data_i.kind == dce_pkg::KindXfer), !out_data_i.accepted,
    "transfer command flagged accepted")

endmodule

bind dma_channel_engine_core dce_checker u_dce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.data.op),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
